>>> rtl/core/lds_pkg.sv
// shared types and constants for the led driver frame sequencer
`default_nettype none
package lds_pkg;

  // event codes carried in the input tuser
  typedef enum logic [2:0] {
    OP_WRITE_GRAY = 3'd0,
    OP_START_GRAY = 3'd1,
    OP_START_FUN  = 3'd2,
    OP_START_LOOP = 3'd3,
    OP_BYTE_SENT  = 3'd4,
    OP_BYTE_RX    = 3'd5
  } op_e;

  // frame in progress
  typedef enum logic [1:0] {
    KIND_IDLE = 2'd0,
    KIND_GRAY = 2'd1,
    KIND_FUN  = 2'd2,
    KIND_LOOP = 2'd3
  } kind_e;

  // configuration register indexes
  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_BLANK      = 3'd1;
  localparam logic [2:0] REG_DOT_BLUE   = 3'd2;
  localparam logic [2:0] REG_DOT_GREEN  = 3'd3;
  localparam logic [2:0] REG_DOT_RED    = 3'd4;

  // frame constants
  localparam logic [7:0] HDR_GRAY     = 8'h00;
  localparam logic [7:0] HDR_FUN      = 8'h01;
  localparam int unsigned FUN_LEN     = 34;
  localparam int unsigned NARROW_FROM = 18;
  localparam int unsigned LOOP_SENDS  = 33;
  localparam logic [15:0] GRAY_RESET  = 16'h0fff;

  // configuration registers
  typedef struct packed {
    logic [6:0] brightness;
    logic       blank;
    logic [6:0] dot_blue;
    logic [6:0] dot_green;
    logic [6:0] dot_red;
  } cfg_t;

  // one result on its way to the output register
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        seven_bit;
    logic        latch_pulse;
    logic        busy_res;
    logic        rejected;
    logic        loop_done;
    logic        loop_fail;
    logic        from_ram;   // tx_byte comes from the gray store
    logic        low_byte;   // take the low byte of the gray word
    logic        ram_hit;    // entry was written since reset
    logic [15:0] fall_word;  // reset value of the entry
  } res_t;

  // function frame byte by index
  function automatic logic [7:0] fun_byte(input logic [5:0] idx, input cfg_t cfg);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      6'd15: b = 8'h01;
      6'd16: b = cfg.blank ? 8'h85 : 8'h87;
      6'd17: b = {cfg.blank, cfg.brightness};
      6'd18: b = 8'h7f;
      6'd19, 6'd22, 6'd25, 6'd28, 6'd31: b = {1'b0, cfg.dot_blue};
      6'd20, 6'd23, 6'd26, 6'd29, 6'd32: b = {1'b0, cfg.dot_green};
      6'd21, 6'd24, 6'd27, 6'd30, 6'd33: b = {1'b0, cfg.dot_red};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/led_driver_frame_sequencer_core.sv
// top level of the led driver frame sequencer
//
// Each input transaction is one event: write a grayscale word, start a
// grayscale, function or loopback frame, report a finished serial byte, or
// deliver a received byte. Every event produces exactly one result
// transaction with the byte to send, 7-bit mode, latch pulse, busy, reject
// and loopback status.
// Throughput is one event per cycle unless a receiver stall fills both
// pipeline entries; the grayscale store is a registered-read ram, read in
// the accept cycle and merged into the result when it moves from the stage
// register into the output register.
// A two-entry pipeline (stage register plus output register) keeps input
// accepted while a result waits; when the receiver stalls, tready falls only
// after both entries are full, and results are never lost or repeated.
// Reset idles the sequencer, loads default configuration and marks all
// grayscale entries unwritten (channel 0 reads 0, the others 0x0fff).
// Users write configuration over the apb port only while idle; the block does not enforce it.
`default_nettype none
module led_driver_frame_sequencer_core #(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input events
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // channel, gray_value, pattern, rx_data, zero pad
  input  wire logic [2:0]  s_axis_tuser,  // operation
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // tx_valid, tx_byte, seven_bit, latch_pulse,
                                          // busy_res, rejected, loop_done, loop_fail, zero pad
);
  import lds_pkg::*;

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t            cfg_q, cfg_d;
  logic            cfg_we;
  logic [2:0]      reg_idx;
  logic            s1_valid;
  res_t            s1;
  logic            out_ready;
  logic            ram_we;
  logic [CH_W-1:0] ram_waddr;
  logic [15:0]     ram_wdata;
  logic            ram_re;
  logic [CH_W-1:0] ram_raddr;
  logic [15:0]     ram_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  // configuration register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_idx)
        REG_BRIGHTNESS: cfg_d.brightness = pwdata[6:0];
        REG_BLANK:      cfg_d.blank      = pwdata[0];
        REG_DOT_BLUE:   cfg_d.dot_blue   = pwdata[6:0];
        REG_DOT_GREEN:  cfg_d.dot_green  = pwdata[6:0];
        REG_DOT_RED:    cfg_d.dot_red    = pwdata[6:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  // configuration register read
  always_comb begin
    case (reg_idx)
      REG_BRIGHTNESS: prdata = {25'd0, cfg_q.brightness};
      REG_BLANK:      prdata = {31'd0, cfg_q.blank};
      REG_DOT_BLUE:   prdata = {25'd0, cfg_q.dot_blue};
      REG_DOT_GREEN:  prdata = {25'd0, cfg_q.dot_green};
      REG_DOT_RED:    prdata = {25'd0, cfg_q.dot_red};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness <= 7'd127;
      cfg_q.blank      <= 1'b0;
      cfg_q.dot_blue   <= 7'd127;
      cfg_q.dot_green  <= 7'd127;
      cfg_q.dot_red    <= 7'd127;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // sequencing control
  lds_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .channel_i    (s_axis_tdata[3:0]),
    .gray_value_i (s_axis_tdata[19:4]),
    .pattern_i    (s_axis_tdata[27:20]),
    .rx_data_i    (s_axis_tdata[35:28]),
    .s1_valid_o   (s1_valid),
    .s1_o         (s1),
    .out_ready_i  (out_ready),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  // grayscale store
  lds_ram #(
    .WIDTH (16),
    .DEPTH (CHANNELS)
  ) u_gray_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  lds_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1),
    .ram_rdata_i (ram_rdata),
    .out_ready_o (out_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> rtl/core/lds_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module lds_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lds_ctrl.sv
// frame sequencing control, gray store access and first pipeline stage
`default_nettype none
module lds_ctrl #(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lds_pkg::cfg_t       cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [2:0]          op_i,
  input  wire logic [3:0]          channel_i,
  input  wire logic [15:0]         gray_value_i,
  input  wire logic [7:0]          pattern_i,
  input  wire logic [7:0]          rx_data_i,
  output logic                     s1_valid_o,
  output lds_pkg::res_t            s1_o,
  input  wire logic                out_ready_i,
  output logic                     ram_we_o,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ram_waddr_o,
  output logic [15:0]              ram_wdata_o,
  output logic                     ram_re_o,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ram_raddr_o
);
  import lds_pkg::*;

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IDX_RAW = $clog2(2 * CHANNELS + 1);
  localparam int unsigned IDX_W  = (IDX_RAW > 6) ? IDX_RAW : 6;
  localparam logic [IDX_W-1:0] GRAY_LEN = IDX_W'(2 * CHANNELS);
  localparam logic [IDX_W-1:0] FUN_END  = IDX_W'(FUN_LEN);
  localparam logic [IDX_W-1:0] NARROW_IDX = IDX_W'(NARROW_FROM);
  localparam logic [IDX_W-1:0] LOOP_END = IDX_W'(LOOP_SENDS);

  kind_e               kind_q, kind_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                narrow_q, narrow_d;
  logic [7:0]          lpat_q, lpat_d;
  logic [7:0]          lrx_q, lrx_d;
  logic [CHANNELS-1:0] gvalid_q, gvalid_d;
  logic                s1_valid_q, s1_valid_d;
  res_t                s1_q, s1_d;

  logic                accept;
  logic                busy;
  op_e                 op;
  logic [CH_W+3:0]     ch_ext;
  logic                ch_ok;
  logic [CH_W-1:0]     waddr;
  logic [CH_W-1:0]     raddr;
  logic [7:0]          expect_byte;

  assign in_ready_o  = !s1_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign busy        = (kind_q != KIND_IDLE);
  assign op          = op_e'(op_i);
  assign ch_ext      = (CH_W + 4)'(channel_i);
  assign ch_ok       = ({28'd0, channel_i} < CHANNELS);
  assign waddr       = ch_ext[CH_W-1:0];
  assign raddr       = idx_q[CH_W:1];
  assign expect_byte = {lpat_q[0], lpat_q[7:1]};

  // next frame kind
  always_comb begin
    kind_d = kind_q;
    if (accept) begin
      case (op)
        OP_START_GRAY: if (!busy) kind_d = KIND_GRAY;
        OP_START_FUN:  if (!busy) kind_d = KIND_FUN;
        OP_START_LOOP: if (!busy) kind_d = KIND_LOOP;
        OP_BYTE_SENT: begin
          case (kind_q)
            KIND_GRAY: if (idx_q >= GRAY_LEN) kind_d = KIND_IDLE;
            KIND_FUN:  if (idx_q >= FUN_END) kind_d = KIND_IDLE;
            KIND_LOOP: if (idx_q >= LOOP_END) kind_d = KIND_IDLE;
            default:   kind_d = kind_q;
          endcase
        end
        default: kind_d = kind_q;
      endcase
    end
  end

  // datapath state, store access and result fields
  always_comb begin
    idx_d     = idx_q;
    narrow_d  = narrow_q;
    lpat_d    = lpat_q;
    lrx_d     = lrx_q;
    gvalid_d  = gvalid_q;
    s1_d      = '0;
    ram_we_o  = 1'b0;
    ram_re_o  = 1'b0;
    if (accept) begin
      case (op)
        OP_WRITE_GRAY: begin
          if (busy) begin
            s1_d.rejected = 1'b1;
          end else if (ch_ok) begin
            ram_we_o        = 1'b1;
            gvalid_d[waddr] = 1'b1;
          end
        end
        OP_START_GRAY, OP_START_FUN, OP_START_LOOP: begin
          if (busy) begin
            s1_d.rejected = 1'b1;
          end else begin
            idx_d         = '0;
            s1_d.tx_valid = 1'b1;
            if (op == OP_START_GRAY) begin
              s1_d.tx_byte = HDR_GRAY;
            end else if (op == OP_START_FUN) begin
              s1_d.tx_byte = HDR_FUN;
            end else begin
              lpat_d       = pattern_i;
              s1_d.tx_byte = pattern_i;
            end
          end
        end
        OP_BYTE_SENT: begin
          case (kind_q)
            KIND_GRAY: begin
              if (idx_q >= GRAY_LEN) begin
                s1_d.latch_pulse = 1'b1;
              end else begin
                ram_re_o       = 1'b1;
                s1_d.from_ram  = 1'b1;
                s1_d.low_byte  = idx_q[0];
                s1_d.ram_hit   = gvalid_q[raddr];
                s1_d.fall_word = (raddr == '0) ? 16'h0000 : GRAY_RESET;
                s1_d.tx_valid  = 1'b1;
                idx_d          = idx_q + 1'b1;
              end
            end
            KIND_FUN: begin
              if (idx_q >= FUN_END) begin
                s1_d.latch_pulse = 1'b1;
                narrow_d         = 1'b0;
              end else begin
                if (idx_q == NARROW_IDX) narrow_d = 1'b1;
                s1_d.tx_byte  = fun_byte(idx_q[5:0], cfg_i);
                s1_d.tx_valid = 1'b1;
                idx_d         = idx_q + 1'b1;
              end
            end
            KIND_LOOP: begin
              if (idx_q >= LOOP_END) begin
                s1_d.loop_done = 1'b1;
                s1_d.loop_fail = (lrx_q != expect_byte);
              end else begin
                s1_d.tx_byte  = lpat_q;
                s1_d.tx_valid = 1'b1;
                idx_d         = idx_q + 1'b1;
              end
            end
            default: idx_d = idx_q;
          endcase
        end
        OP_BYTE_RX: begin
          if (kind_q == KIND_LOOP) lrx_d = rx_data_i;
        end
        default: idx_d = idx_q;
      endcase
    end
    s1_d.seven_bit = s1_d.tx_valid && narrow_d;
    s1_d.busy_res  = (kind_d != KIND_IDLE);
  end

  assign ram_waddr_o = waddr;
  assign ram_wdata_o = gray_value_i;
  assign ram_raddr_o = raddr;

  // stage occupancy
  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (out_ready_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= KIND_IDLE;
      idx_q      <= '0;
      narrow_q   <= 1'b0;
      lpat_q     <= 8'h00;
      lrx_q      <= 8'h00;
      gvalid_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      kind_q     <= kind_d;
      idx_q      <= idx_d;
      narrow_q   <= narrow_d;
      lpat_q     <= lpat_d;
      lrx_q      <= lrx_d;
      gvalid_q   <= gvalid_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule
`default_nettype wire

>>> rtl/core/lds_out.sv
// output register: merges gray store data and holds the result for the receiver
`default_nettype none
module lds_out (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s1_valid_i,
  input  wire lds_pkg::res_t s1_i,
  input  wire logic [15:0]   ram_rdata_i,
  output logic               out_ready_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output logic [15:0]        m_data_o
);
  import lds_pkg::*;

  logic        valid_q, valid_d;
  logic [15:0] data_q, data_d;
  logic [15:0] word;
  logic [7:0]  tx_byte;

  assign out_ready_o = !valid_q || m_ready_i;

  // select transmit byte from the store word when needed
  always_comb begin
    word    = s1_i.ram_hit ? ram_rdata_i : s1_i.fall_word;
    tx_byte = s1_i.tx_byte;
    if (s1_i.from_ram) begin
      tx_byte = s1_i.low_byte ? word[7:0] : word[15:8];
    end
    data_d  = {1'b0, s1_i.loop_fail, s1_i.loop_done, s1_i.rejected, s1_i.busy_res,
               s1_i.latch_pulse, s1_i.seven_bit, tx_byte, s1_i.tx_valid};
    valid_d = out_ready_o ? s1_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_o && s1_valid_i) begin
      data_q <= data_d;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule
`default_nettype wire

>>> verif/led_driver_frame_sequencer_core_tb.sv
// self-checking testbench for the led driver frame sequencer core
`timescale 1ns / 1ps
module led_driver_frame_sequencer_core_tb;
  import lds_pkg::*;

  localparam int unsigned CHANNELS        = 16;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned ITEMS_PER_PHASE = 190;
  localparam int unsigned PHASES          = 5;
  localparam int unsigned REPORT_LIMIT    = 10;
  // operation codes the block has no use for
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // one input event, as carried by tuser and tdata
  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  channel;
    logic [15:0] gray_value;
    logic [7:0]  pattern;
    logic [7:0]  rx_data;
  } seq_event_t;

  // one result; field order matches m_axis_tdata[14:0] from the top bit down
  typedef struct packed {
    logic       loop_fail;
    logic       loop_done;
    logic       rejected;
    logic       busy_res;
    logic       latch_pulse;
    logic       seven_bit;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } seq_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // channel, gray_value, pattern, rx_data, zero pad
  logic [2:0]  s_axis_tuser = '0;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // tx_valid, tx_byte, seven_bit, latch_pulse,
                                   // busy_res, rejected, loop_done, loop_fail, zero pad

  // sequencer mirror
  kind_e       seq_kind;
  logic [5:0]  seq_index;
  logic [15:0] gray_mirror [CHANNELS];
  logic [7:0]  loop_pat;
  logic [7:0]  loop_rx;
  logic        narrow_q;
  cfg_t        cfg_mirror;

  seq_event_t  pending_events[$];
  seq_result_t expected_results_q[$];

  int unsigned pushed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;

  // driver and monitor private state
  seq_event_t  drv_event = '0;
  bit          offering = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;

  always #5 clk_i = ~clk_i;

  led_driver_frame_sequencer_core #(
    .CHANNELS(CHANNELS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // function frame byte at a given index under the current settings
  function automatic logic [7:0] function_frame_byte(input logic [5:0] idx);
    int k;
    k = (int'(idx) - 19) % 3;
    if (idx < 6'd15) return 8'h00;
    if (idx == 6'd15) return 8'h01;
    if (idx == 6'd16) return cfg_mirror.blank ? 8'h85 : 8'h87;
    if (idx == 6'd17) return {cfg_mirror.blank, cfg_mirror.brightness};
    if (idx == 6'd18) return 8'h7f;
    if (idx >= FUN_LEN) return 8'h00;
    if (k == 0) return {1'b0, cfg_mirror.dot_blue};
    if (k == 1) return {1'b0, cfg_mirror.dot_green};
    return {1'b0, cfg_mirror.dot_red};
  endfunction

  task automatic reset_mirror;
    seq_kind   = KIND_IDLE;
    seq_index  = '0;
    loop_pat   = '0;
    loop_rx    = '0;
    narrow_q   = 1'b0;
    cfg_mirror = '{brightness: 7'd127, blank: 1'b0, dot_blue: 7'd127,
                   dot_green: 7'd127, dot_red: 7'd127};
    for (int i = 0; i < CHANNELS; i++) gray_mirror[i] = (i == 0) ? 16'h0000 : GRAY_RESET;
  endtask

  // advance the mirror by one event and queue the result it must produce
  task automatic advance_sequencer(input seq_event_t ev);
    seq_result_t r;
    logic        was_busy;
    logic [15:0] w;
    logic [7:0]  rot;
    r = '0;
    was_busy = (seq_kind != KIND_IDLE);
    case (ev.op)
      OP_WRITE_GRAY: begin
        if (was_busy) r.rejected = 1'b1;
        else if (ev.channel < CHANNELS) gray_mirror[ev.channel] = ev.gray_value;
      end
      OP_START_GRAY, OP_START_FUN, OP_START_LOOP: begin
        if (was_busy) begin
          r.rejected = 1'b1;
        end else begin
          seq_index = '0;
          r.tx_valid = 1'b1;
          if (ev.op == OP_START_GRAY) begin
            seq_kind = KIND_GRAY;
            r.tx_byte = HDR_GRAY;
          end else if (ev.op == OP_START_FUN) begin
            seq_kind = KIND_FUN;
            r.tx_byte = HDR_FUN;
          end else begin
            seq_kind = KIND_LOOP;
            loop_pat = ev.pattern;
            r.tx_byte = ev.pattern;
          end
        end
      end
      OP_BYTE_SENT: begin
        case (seq_kind)
          KIND_GRAY: begin
            if (seq_index >= 2 * CHANNELS) begin
              r.latch_pulse = 1'b1;
              seq_kind = KIND_IDLE;
            end else begin
              w = gray_mirror[seq_index[4:1]];
              r.tx_byte = seq_index[0] ? w[7:0] : w[15:8];
              r.tx_valid = 1'b1;
              seq_index = seq_index + 6'd1;
            end
          end
          KIND_FUN: begin
            if (seq_index >= FUN_LEN) begin
              r.latch_pulse = 1'b1;
              narrow_q = 1'b0;
              seq_kind = KIND_IDLE;
            end else begin
              if (seq_index == NARROW_FROM) narrow_q = 1'b1;
              r.tx_byte = function_frame_byte(seq_index);
              r.tx_valid = 1'b1;
              seq_index = seq_index + 6'd1;
            end
          end
          KIND_LOOP: begin
            if (seq_index >= LOOP_SENDS) begin
              rot = {loop_pat[0], loop_pat[7:1]};
              r.loop_done = 1'b1;
              r.loop_fail = (loop_rx != rot);
              seq_kind = KIND_IDLE;
            end else begin
              r.tx_byte = loop_pat;
              r.tx_valid = 1'b1;
              seq_index = seq_index + 6'd1;
            end
          end
          default: ;
        endcase
      end
      OP_BYTE_RX: begin
        if (seq_kind == KIND_LOOP) loop_rx = ev.rx_data;
      end
      default: ;
    endcase
    r.seven_bit = r.tx_valid ? narrow_q : 1'b0;
    r.busy_res = (seq_kind != KIND_IDLE);
    expected_results_q.push_back(r);
  endtask

  function automatic string describe(input seq_result_t r);
    return $sformatf("valid=%0d byte=%02h seven=%0d latch=%0d busy=%0d rej=%0d done=%0d fail=%0d",
                     r.tx_valid, r.tx_byte, r.seven_bit, r.latch_pulse, r.busy_res,
                     r.rejected, r.loop_done, r.loop_fail);
  endfunction

  // input driver: holds one event on the bus until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      offering = 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_sequencer(drv_event);
        accepted_cnt++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_events.size() > 0) begin
          if (!no_idle && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 15);
          end else begin
            drv_event = pending_events.pop_front();
            offering = 1'b1;
          end
        end
      end
      s_axis_tvalid <= offering;
      s_axis_tdata  <= {4'b0, drv_event.rx_data, drv_event.pattern,
                        drv_event.gray_value, drv_event.channel};
      s_axis_tuser  <= drv_event.op;
    end
  end

  // result monitor with random stalls and two long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    seq_result_t got;
    seq_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = seq_result_t'(m_axis_tdata[14:0]);
        if (expected_results_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: %s", $time, describe(got));
        end else begin
          want = expected_results_q.pop_front();
          checked_cnt++;
          if (got !== want) begin
            error_cnt++;
            if (error_cnt <= REPORT_LIMIT)
              $display("%0t: result %0d mismatch\n  expected %s\n  actual   %s",
                       $time, checked_cnt, describe(want), describe(got));
          end
          if (checked_cnt == 200 || checked_cnt == 900) hold_left = HOLD_OFF_CYCLES;
        end
      end
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
      else if (!no_idle && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 15);
      m_axis_tready <= (hold_left == 0) && (stall_left == 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [31:0] register_mask(input logic [2:0] idx);
    return (idx == REG_BLANK) ? 32'h1 : 32'h7f;
  endfunction

  // register write followed by a read back
  task automatic program_register(input logic [2:0] idx, input logic [6:0] value);
    logic [31:0] wdata;
    logic [31:0] sampled;
    wdata = {25'($urandom_range(0, 32'h01ff_ffff)), value};
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BRIGHTNESS: cfg_mirror.brightness = wdata[6:0];
      REG_BLANK:      cfg_mirror.blank = wdata[0];
      REG_DOT_BLUE:   cfg_mirror.dot_blue = wdata[6:0];
      REG_DOT_GREEN:  cfg_mirror.dot_green = wdata[6:0];
      REG_DOT_RED:    cfg_mirror.dot_red = wdata[6:0];
      default: ;
    endcase
    @(posedge clk_i);
    psel <= 1'b1;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sampled = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if ((sampled & register_mask(idx)) !== (wdata & register_mask(idx))) begin
      error_cnt++;
      if (error_cnt <= REPORT_LIMIT)
        $display("%0t: register %0d read %08h, wrote %08h", $time, idx, sampled, wdata);
    end
  endtask

  task automatic program_settings(input logic [6:0] bright, input logic blank_bit,
                                  input logic [6:0] blue, input logic [6:0] green,
                                  input logic [6:0] red);
    program_register(REG_BRIGHTNESS, bright);
    program_register(REG_BLANK, {6'b0, blank_bit});
    program_register(REG_DOT_BLUE, blue);
    program_register(REG_DOT_GREEN, green);
    program_register(REG_DOT_RED, red);
  endtask

  function automatic seq_event_t random_event(input logic [2:0] op);
    seq_event_t ev;
    ev.op = op;
    ev.channel = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0: ev.gray_value = 16'h0000;
      1: ev.gray_value = 16'hffff;
      default: ev.gray_value = 16'($urandom_range(0, 16'hffff));
    endcase
    ev.pattern = 8'($urandom_range(0, 255));
    ev.rx_data = 8'($urandom_range(0, 255));
    return ev;
  endfunction

  task automatic push_event(input seq_event_t ev);
    pending_events.push_back(ev);
    pushed_cnt++;
  endtask

  // occasional stray event inside a frame: busy starts and writes, stray rx, spare codes
  task automatic maybe_noise;
    logic [2:0] op;
    if ($urandom_range(0, 9) == 0) begin
      op = 3'($urandom_range(0, 6));
      if (op >= OP_BYTE_SENT) op = op + 3'd1;
      push_event(random_event(op));
    end
  endtask

  task automatic send_gray_frame;
    push_event(random_event(OP_START_GRAY));
    repeat (2 * CHANNELS + 1) begin
      maybe_noise();
      push_event(random_event(OP_BYTE_SENT));
    end
  endtask

  task automatic send_function_frame;
    push_event(random_event(OP_START_FUN));
    repeat (FUN_LEN + 1) begin
      maybe_noise();
      push_event(random_event(OP_BYTE_SENT));
    end
  endtask

  // rx_mode 0: echo matches, 1: random echo, 2: no echo at all
  task automatic send_loopback_frame(input int unsigned rx_mode);
    seq_event_t ev;
    logic [7:0] pat;
    ev = random_event(OP_START_LOOP);
    case ($urandom_range(0, 5))
      0: ev.pattern = 8'h00;
      1: ev.pattern = 8'hff;
      2: ev.pattern = 8'h01;
      default: ;
    endcase
    pat = ev.pattern;
    push_event(ev);
    for (int i = 0; i < LOOP_SENDS; i++) begin
      push_event(random_event(OP_BYTE_SENT));
      maybe_noise();
      if (rx_mode != 2) begin
        ev = random_event(OP_BYTE_RX);
        if (rx_mode == 0 && i == LOOP_SENDS - 1) ev.rx_data = {pat[0], pat[7:1]};
        push_event(ev);
      end
    end
    push_event(random_event(OP_BYTE_SENT));
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned start_cnt;
    start_cnt = pushed_cnt;
    while (pushed_cnt - start_cnt < budget) begin
      case ($urandom_range(0, 9))
        0, 1: send_gray_frame();
        2: send_function_frame();
        3, 4, 5: send_loopback_frame($urandom_range(0, 2));
        6, 7: repeat ($urandom_range(1, 6)) push_event(random_event(OP_WRITE_GRAY));
        default: repeat ($urandom_range(1, 4))
          push_event(random_event(3'($urandom_range(0, 7))));
      endcase
    end
    // close any frame a stray start left open
    repeat (FUN_LEN + 2) push_event(random_event(OP_BYTE_SENT));
  endtask

  task automatic wait_for_drain;
    while (accepted_cnt != pushed_cnt || expected_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // stimulus sequence and end of run
  initial begin
    seq_event_t ev;
    reset_mirror();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle events that must do nothing
    push_event(random_event(OP_BYTE_SENT));
    push_event(random_event(OP_BYTE_RX));
    push_event(random_event(OP_SPARE_6));
    push_event(random_event(OP_SPARE_7));
    // grayscale frame from reset contents, with busy starts and writes inside
    push_event(random_event(OP_START_GRAY));
    push_event(random_event(OP_START_GRAY));
    push_event(random_event(OP_WRITE_GRAY));
    push_event(random_event(OP_START_FUN));
    push_event(random_event(OP_START_LOOP));
    push_event(random_event(OP_BYTE_RX));
    repeat (2 * CHANNELS + 1) push_event(random_event(OP_BYTE_SENT));
    // extreme gray words at the edge channels
    ev = random_event(OP_WRITE_GRAY);
    ev.channel = 4'd0;
    ev.gray_value = 16'hffff;
    push_event(ev);
    ev.channel = 4'd15;
    ev.gray_value = 16'h0000;
    push_event(ev);
    send_function_frame();
    send_gray_frame();
    wait_for_drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_settings(7'd0, 1'b1, 7'd0, 7'd0, 7'd0);
        1: program_settings(7'd127, 1'b0, 7'd127, 7'd127, 7'd127);
        default: program_settings(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                                  7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                  7'($urandom_range(0, 127)));
      endcase
      if (p == PHASES - 1) no_idle = 1'b1;
      random_traffic(ITEMS_PER_PHASE);
      wait_for_drain();
    end

    repeat (8) @(posedge clk_i);
    error_cnt += expected_results_q.size();
    if (error_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
